@@ rtl/sliding_window_max_min_assert.svh @@
// Assertion macros used by the sliding window block.
`ifndef SLIDING_WINDOW_MAX_MIN_ASSERT_SVH
`define SLIDING_WINDOW_MAX_MIN_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWMM_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWMM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/swmm_pkg.sv @@
`timescale 1ns / 1ps
package swmm_pkg;

    localparam int MAX_WINDOW_DEF  = 64;
    localparam int PRICE_WIDTH_DEF = 32;
    localparam int CFG_WIDTH       = 7;
    localparam int LENGTH_RESET    = 1;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

endpackage

@@ rtl/sliding_window_max_min.sv @@
// Sliding window maximum and minimum over a chain of MAX_WINDOW sample cells.
// A result passes from the input transfer through the launch register, the comparison wave along the cell
// chain, the pending register and the output register. A new sample is taken only after the previous result
// has moved into the output register; the comparison wave walks the cell chain one cell per cycle.
// Reset (synchronous, active low) and every window_length write empty the window;
// reset sets window_length to 1.
`timescale 1ns / 1ps
module sliding_window_max_min
    import swmm_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int PRICE_WIDTH = PRICE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_WIDTH-1:0]          i_cfg_window_length,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [PRICE_WIDTH-1:0] i_price,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [PRICE_WIDTH-1:0] o_window_max,
    output logic signed [PRICE_WIDTH-1:0] o_window_min
);

    `include "sliding_window_max_min_assert.svh"

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int EW    = (CNT_W > CFG_WIDTH) ? CNT_W : CFG_WIDTH;

    logic                          cfg_write;
    logic                          in_accept;
    logic                          out_load;
    logic [EW-1:0]                 r_eff;
    logic [EW-1:0]                 n_eff;
    logic                          r_busy;
    logic                          r_launch;
    logic                          r_pend_vld;
    logic signed [PRICE_WIDTH-1:0] r_pend_max;
    logic signed [PRICE_WIDTH-1:0] r_pend_min;
    logic                          r_out_valid;
    logic signed [PRICE_WIDTH-1:0] r_out_max;
    logic signed [PRICE_WIDTH-1:0] r_out_min;
    t_cell_ctrl                    cell_ctrl;

    logic signed [PRICE_WIDTH-1:0] chain_value [MAX_WINDOW+1];
    logic                          chain_valid [MAX_WINDOW+1];
    logic                          wave_vld    [MAX_WINDOW+1];
    logic signed [PRICE_WIDTH-1:0] wave_max    [MAX_WINDOW+1];
    logic signed [PRICE_WIDTH-1:0] wave_min    [MAX_WINDOW+1];
    logic [MAX_WINDOW-1:0]         wave_vec;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign o_in_ready  = !r_busy;
    assign in_accept   = i_in_valid && o_in_ready;
    assign out_load    = r_pend_vld && (!r_out_valid || i_out_ready);

    always_comb begin
        if (i_cfg_window_length == '0) begin
            n_eff = EW'(1);
        end else if (EW'(i_cfg_window_length) > EW'(MAX_WINDOW)) begin
            n_eff = EW'(MAX_WINDOW);
        end else begin
            n_eff = EW'(i_cfg_window_length);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff <= EW'(LENGTH_RESET);
        end else if (cfg_write) begin
            r_eff <= n_eff;
        end
    end

    assign cell_ctrl.shift = in_accept;
    assign cell_ctrl.clear = cfg_write;

    // The newest sample enters cell 0; the wave starts in the cycle after the sample is accepted.
    assign chain_value[0] = i_price;
    assign chain_valid[0] = 1'b1;
    assign wave_vld[0]    = r_launch;
    assign wave_max[0]    = chain_value[1];
    assign wave_min[0]    = chain_value[1];

    for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
        logic in_window;

        assign in_window   = EW'(k) < r_eff;
        assign wave_vec[k] = wave_vld[k+1];

        swmm_cell #(
            .PRICE_WIDTH(PRICE_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (cell_ctrl),
            .i_in_window (in_window),
            .i_prev_value(chain_value[k]),
            .i_prev_valid(chain_valid[k]),
            .o_value     (chain_value[k+1]),
            .o_valid     (chain_valid[k+1]),
            .i_wave_vld  (wave_vld[k]),
            .i_wave_max  (wave_max[k]),
            .i_wave_min  (wave_min[k]),
            .o_wave_vld  (wave_vld[k+1]),
            .o_wave_max  (wave_max[k+1]),
            .o_wave_min  (wave_min[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_launch    <= 1'b0;
            r_pend_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_launch <= in_accept;
            if (in_accept) begin
                r_busy <= 1'b1;
            end else if (out_load) begin
                r_busy <= 1'b0;
            end
            if (wave_vld[MAX_WINDOW]) begin
                r_pend_vld <= 1'b1;
            end else if (out_load) begin
                r_pend_vld <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wave_vld[MAX_WINDOW]) begin
            r_pend_max <= wave_max[MAX_WINDOW];
            r_pend_min <= wave_min[MAX_WINDOW];
        end
        if (out_load) begin
            r_out_max <= r_pend_max;
            r_out_min <= r_pend_min;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_window_max = r_out_max;
    assign o_window_min = r_out_min;

    `SWMM_ASSERT_NEXT(a_accept_sets_busy, i_clk, i_rst_n, in_accept, r_busy, "accept did not set busy")
    `SWMM_ASSERT_SAME(a_single_wave, i_clk, i_rst_n, 1'b1, $onehot0(wave_vec), "more than one wave in the chain")
    `SWMM_ASSERT_NEXT(a_wave_end_pends, i_clk, i_rst_n, wave_vld[MAX_WINDOW], r_pend_vld, "wave result was lost")
    `SWMM_ASSERT_SAME(a_accept_idle, i_clk, i_rst_n, in_accept, !r_pend_vld && !r_launch, "accept while a result is pending")

endmodule

@@ rtl/swmm_cell.sv @@
`timescale 1ns / 1ps
module swmm_cell
    import swmm_pkg::*;
#(
    parameter int PRICE_WIDTH = PRICE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cell_ctrl                    i_ctrl,
    input  logic                          i_in_window,
    input  logic signed [PRICE_WIDTH-1:0] i_prev_value,
    input  logic                          i_prev_valid,
    output logic signed [PRICE_WIDTH-1:0] o_value,
    output logic                          o_valid,
    input  logic                          i_wave_vld,
    input  logic signed [PRICE_WIDTH-1:0] i_wave_max,
    input  logic signed [PRICE_WIDTH-1:0] i_wave_min,
    output logic                          o_wave_vld,
    output logic signed [PRICE_WIDTH-1:0] o_wave_max,
    output logic signed [PRICE_WIDTH-1:0] o_wave_min
);

    logic signed [PRICE_WIDTH-1:0] r_value;
    logic                          r_valid;
    logic                          r_wave_vld;
    logic signed [PRICE_WIDTH-1:0] r_wave_max;
    logic signed [PRICE_WIDTH-1:0] r_wave_min;
    logic signed [PRICE_WIDTH-1:0] n_wave_max;
    logic signed [PRICE_WIDTH-1:0] n_wave_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_valid <= i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_value <= i_prev_value;
        end
    end

    // A sample joins the running extremes only while it is inside the window.
    always_comb begin
        n_wave_max = i_wave_max;
        n_wave_min = i_wave_min;
        if (r_valid && i_in_window) begin
            if (r_value > i_wave_max) begin
                n_wave_max = r_value;
            end
            if (r_value < i_wave_min) begin
                n_wave_min = r_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_vld <= 1'b0;
        end else begin
            r_wave_vld <= i_wave_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wave_max <= n_wave_max;
        r_wave_min <= n_wave_min;
    end

    assign o_value    = r_value;
    assign o_valid    = r_valid;
    assign o_wave_vld = r_wave_vld;
    assign o_wave_max = r_wave_max;
    assign o_wave_min = r_wave_min;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import swmm_pkg::*;

    localparam int MAX_W     = MAX_WINDOW_DEF;
    localparam int PW        = PRICE_WIDTH_DEF;
    localparam int N_ITEMS   = 1900;
    localparam int LONG_HOLD = 600;
    localparam int N_ROWS    = 27;

    typedef logic signed [PW-1:0] t_price;
    typedef logic [CFG_WIDTH-1:0] t_length;

    typedef struct packed {
        t_price hi;
        t_price lo;
    } t_extremes;

    typedef struct packed {
        logic    is_len_write;
        t_length length;
        t_price  price;
        logic    typed;
        t_price  want_max;
        t_price  want_min;
    } t_row;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    cfg_valid = 1'b0;
    t_length cfg_len   = '0;
    logic    in_valid  = 1'b0;
    t_price  in_price  = '0;
    logic    out_ready = 1'b0;
    logic    cfg_ready;
    logic    in_ready;
    logic    out_valid;
    t_price  win_max;
    t_price  win_min;

    t_price    win_prices [MAX_W];
    logic      win_valid  [MAX_W];
    t_length   win_len;
    t_extremes pending_extremes [$];
    t_price    ramp          = '0;
    int        fail_count    = 0;
    int        items_sent    = 0;
    bit        long_hold_req = 1'b0;
    bit        tx_quiet      = 1'b0;

    t_row directed_rows [N_ROWS] = '{
        '{1'b0, 7'd0,   32'sh7FFF_FFFF, 1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF},
        '{1'b0, 7'd0,   32'sh8000_0000, 1'b1, 32'sh8000_0000, 32'sh8000_0000},
        '{1'b0, 7'd0,   -32'sd1,        1'b1, -32'sd1,        -32'sd1},
        '{1'b1, 7'd0,   32'sd0,         1'b0, 32'sd0,         32'sd0},
        '{1'b0, 7'd0,   32'sd5,         1'b1, 32'sd5,         32'sd5},
        '{1'b0, 7'd0,   -32'sd7,        1'b1, -32'sd7,        -32'sd7},
        '{1'b1, 7'd3,   32'sd0,         1'b0, 32'sd0,         32'sd0},
        '{1'b0, 7'd0,   32'sd10,        1'b0, 32'sd0,         32'sd0},
        '{1'b0, 7'd0,   32'sd10,        1'b0, 32'sd0,         32'sd0},
        '{1'b0, 7'd0,   32'sd3,         1'b0, 32'sd0,         32'sd0},
        '{1'b0, 7'd0,   32'sd10,        1'b0, 32'sd0,         32'sd0},
        '{1'b0, 7'd0,   32'sd2,         1'b0, 32'sd0,         32'sd0},
        '{1'b1, 7'd3,   32'sd0,         1'b0, 32'sd0,         32'sd0},
        '{1'b0, 7'd0,   -32'sd5,        1'b1, -32'sd5,        -32'sd5},
        '{1'b1, 7'd127, 32'sd0,         1'b0, 32'sd0,         32'sd0},
        '{1'b0, 7'd0,   32'sh7FFF_FFFF, 1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF},
        '{1'b0, 7'd0,   32'sh8000_0000, 1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000},
        '{1'b0, 7'd0,   32'sd0,         1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000},
        '{1'b1, 7'd64,  32'sd0,         1'b0, 32'sd0,         32'sd0},
        '{1'b0, 7'd0,   32'sd1,         1'b1, 32'sd1,         32'sd1},
        '{1'b1, 7'd65,  32'sd0,         1'b0, 32'sd0,         32'sd0},
        '{1'b0, 7'd0,   32'sd2,         1'b1, 32'sd2,         32'sd2},
        '{1'b1, 7'd2,   32'sd0,         1'b0, 32'sd0,         32'sd0},
        '{1'b0, 7'd0,   32'sd4,         1'b0, 32'sd0,         32'sd0},
        '{1'b0, 7'd0,   32'sd8,         1'b0, 32'sd0,         32'sd0},
        '{1'b0, 7'd0,   32'sd6,         1'b0, 32'sd0,         32'sd0},
        '{1'b0, 7'd0,   -32'sd3,        1'b0, 32'sd0,         32'sd0}
    };

    sliding_window_max_min u_dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_window_length (cfg_len),
        .i_in_valid          (in_valid),
        .o_in_ready          (in_ready),
        .i_price             (in_price),
        .o_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .o_window_max        (win_max),
        .o_window_min        (win_min)
    );

    always #5 clk = ~clk;

    function automatic void clear_window();
        for (int a = 0; a < MAX_W; a++) begin
            win_prices[a] = '0;
            win_valid[a]  = 1'b0;
        end
    endfunction

    // Ages the window by one sample and returns its extremes over the effective length.
    function automatic t_extremes slide_window(input t_price p);
        t_extremes r;
        t_price    hi;
        t_price    lo;
        int        span;
        bit        stop;
        span = (win_len == 0) ? 1 : ((win_len > MAX_W) ? MAX_W : int'(win_len));
        for (int a = MAX_W - 1; a > 0; a--) begin
            win_prices[a] = win_prices[a-1];
            win_valid[a]  = win_valid[a-1];
        end
        win_prices[0] = p;
        win_valid[0]  = 1'b1;
        hi   = p;
        lo   = p;
        stop = 1'b0;
        for (int a = 1; a < span; a++) begin
            if (!win_valid[a]) begin
                stop = 1'b1;
            end
            if (!stop && win_prices[a] > hi) begin
                hi = win_prices[a];
            end
            if (!stop && win_prices[a] < lo) begin
                lo = win_prices[a];
            end
        end
        r.hi = hi;
        r.lo = lo;
        return r;
    endfunction

    function automatic t_price draw_price();
        t_price p;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: p = $urandom;
            4, 5, 6:    p = t_price'(int'($urandom_range(0, 8)) - 4);
            7: begin
                case ($urandom_range(0, 3))
                    0:       p = 32'sh7FFF_FFFF;
                    1:       p = 32'sh8000_0000;
                    2:       p = '0;
                    default: p = '1;
                endcase
            end
            default: begin
                ramp = ramp + t_price'(int'($urandom_range(0, 2000)) - 1000);
                p    = ramp;
            end
        endcase
        return p;
    endfunction

    task automatic send_sample(input t_price p, input bit typed,
                               input t_price want_max, input t_price want_min);
        int        gap;
        t_extremes e;
        gap = tx_quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_price <= p;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        e = slide_window(p);
        if (typed) begin
            e.hi = want_max;
            e.lo = want_min;
        end
        pending_extremes = {pending_extremes, e};
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_extremes.size() != 0) @(posedge clk);
    endtask

    task automatic write_length(input t_length v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_len   <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        win_len = v;
        clear_window();
    endtask

    initial begin
        int      phase;
        int      count;
        t_length len;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        win_len = t_length'(LENGTH_RESET);
        clear_window();
        @(posedge clk);
        for (int r = 0; r < N_ROWS; r++) begin
            if (directed_rows[r].is_len_write) begin
                write_length(directed_rows[r].length);
            end else begin
                send_sample(directed_rows[r].price, directed_rows[r].typed,
                            directed_rows[r].want_max, directed_rows[r].want_min);
            end
        end
        phase = 0;
        while (items_sent < N_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       len = 7'd0;
                1:       len = 7'd1;
                2:       len = 7'd64;
                3:       len = 7'd127;
                4:       len = t_length'($urandom_range(65, 127));
                5:       len = t_length'($urandom_range(1, 64));
                default: len = t_length'($urandom_range(1, 12));
            endcase
            write_length(len);
            tx_quiet = ($urandom_range(0, 3) == 0);
            // The output side stalls for a long stretch while samples keep arriving.
            if (phase == 2 || phase == 6) begin
                tx_quiet      = 1'b1;
                long_hold_req = 1'b1;
            end
            count = $urandom_range(10, 150);
            for (int k = 0; k < count; k++) begin
                if (phase == 4 && k == count / 2) begin
                    wait_drained();
                end
                send_sample(draw_price(), 1'b0, '0, '0);
            end
            phase++;
        end
        wait_drained();
        repeat (MAX_W + 8) @(posedge clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        int        stall;
        bit        rx_quiet;
        t_extremes e;
        rx_quiet = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if ($urandom_range(0, 19) == 0) begin
                rx_quiet = !rx_quiet;
            end
            stall = rx_quiet ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            if (pending_extremes.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, got max %0d min %0d",
                         $time, win_max, win_min);
                fail_count++;
            end else begin
                e = pending_extremes[0];
                pending_extremes.delete(0);
                if (win_max !== e.hi) begin
                    $display("%0t: window_max mismatch, expected %0d, got %0d",
                             $time, $signed(e.hi), win_max);
                    fail_count++;
                end
                if (win_min !== e.lo) begin
                    $display("%0t: window_min mismatch, expected %0d, got %0d",
                             $time, $signed(e.lo), win_min);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #15_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
